>>> hdl/drt_pkg.sv
package drt_pkg;

    // Request kinds
    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_WRITE   = 1'b1;

    // Register selects
    localparam logic [1:0] SEL_DIVIDER = 2'd0;
    localparam logic [1:0] SEL_COUNTER = 2'd1;
    localparam logic [1:0] SEL_RELOAD  = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    // Period select codes
    localparam logic [1:0] PER_1024 = 2'd0;
    localparam logic [1:0] PER_16   = 2'd1;
    localparam logic [1:0] PER_64   = 2'd2;
    localparam logic [1:0] PER_256  = 2'd3;

    localparam int CTRL_EN_BIT = 2;
    localparam int CD_W        = 11;

    localparam logic [7:0]      BYTE_MAX     = 8'hFF;
    localparam logic [CD_W-1:0] CD_RESET_VAL = 11'd1024;

    typedef struct packed {
        logic       kind;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [4:0] cycles;
    } t_req;

    typedef struct packed {
        logic [7:0] divider_high;
        logic [7:0] counter_value;
        logic [7:0] reload_value;
        logic [2:0] control_value;
        logic       timer_interrupt;
    } t_rsp;

    typedef struct packed {
        logic [7:0] cnt;
        logic       ovf;
    } t_tick;

    // Countdown length for a period select code
    function automatic logic [CD_W-1:0] period_of(input logic [1:0] sel);
        logic [CD_W-1:0] p;
        case (sel)
            PER_1024: p = 11'd1024;
            PER_16:   p = 11'd16;
            PER_64:   p = 11'd64;
            PER_256:  p = 11'd256;
            default:  p = 11'd1024;
        endcase
        return p;
    endfunction

    // Raise the counter once, load the reload value on overflow
    function automatic t_tick tick(input logic [7:0] cnt, input logic [7:0] rld);
        t_tick t;
        if (cnt == BYTE_MAX) begin
            t.cnt = rld;
            t.ovf = 1'b1;
        end else begin
            t.cnt = cnt + 8'd1;
            t.ovf = 1'b0;
        end
        return t;
    endfunction

endpackage

>>> hdl/drt_req_if.sv
interface drt_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic [4:0] cycles;

    modport source (output valid, kind, reg_select, write_data, cycles, input ready);
    modport sink   (input valid, kind, reg_select, write_data, cycles, output ready);
endinterface

>>> hdl/drt_rsp_if.sv
interface drt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] divider_high;
    logic [7:0] counter_value;
    logic [7:0] reload_value;
    logic [2:0] control_value;
    logic       timer_interrupt;

    modport source (output valid, divider_high, counter_value, reload_value, control_value,
                    timer_interrupt, input ready);
    modport sink   (input valid, divider_high, counter_value, reload_value, control_value,
                    timer_interrupt, output ready);
endinterface

>>> hdl/drt_state.sv
module drt_state (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  drt_pkg::t_req i_item,
    output drt_pkg::t_rsp o_result
);
    import drt_pkg::*;

    logic [15:0]     r_divider;
    logic [7:0]      r_counter;
    logic [7:0]      r_reload;
    logic [2:0]      r_control;
    logic [CD_W-1:0] r_countdown;

    logic [15:0]     n_divider;
    logic [7:0]      n_counter;
    logic [7:0]      n_reload;
    logic [2:0]      n_control;
    logic [CD_W-1:0] n_countdown;
    logic            irq;

    logic [CD_W-1:0] cyc;
    logic [CD_W-1:0] per;
    logic [CD_W-1:0] rem;
    t_tick           t1;
    t_tick           t2;

    // Period and tick terms for an advance
    assign cyc = CD_W'(i_item.cycles);
    assign per = period_of(r_control[1:0]);
    assign rem = cyc - r_countdown;
    assign t1  = tick(r_counter, r_reload);
    assign t2  = tick(t1.cnt, r_reload);

    // Next state for one request; at most two expirations fit in one advance
    always_comb begin
        n_divider   = r_divider;
        n_counter   = r_counter;
        n_reload    = r_reload;
        n_control   = r_control;
        n_countdown = r_countdown;
        irq         = 1'b0;
        if (i_item.kind == KIND_ADVANCE) begin
            n_divider = r_divider + 16'(i_item.cycles);
            if (r_control[CTRL_EN_BIT]) begin
                if (cyc < r_countdown) begin
                    n_countdown = r_countdown - cyc;
                end else if (rem < per) begin
                    n_countdown = per - rem;
                    n_counter   = t1.cnt;
                    irq         = t1.ovf;
                end else begin
                    n_countdown = per - (rem - per);
                    n_counter   = t2.cnt;
                    irq         = t1.ovf | t2.ovf;
                end
            end
        end else begin
            case (i_item.reg_select)
                SEL_DIVIDER: n_divider = 16'd0;
                SEL_COUNTER: n_counter = i_item.write_data;
                SEL_RELOAD:  n_reload  = i_item.write_data;
                SEL_CONTROL: begin
                    n_control = i_item.write_data[2:0];
                    // restart the countdown when the timer turns on
                    if (!r_control[CTRL_EN_BIT] && i_item.write_data[CTRL_EN_BIT]) begin
                        n_countdown = period_of(i_item.write_data[1:0]);
                    end
                end
                default: n_control = r_control;
            endcase
        end
    end

    // Hold timer state, advance on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider   <= '0;
            r_counter   <= '0;
            r_reload    <= '0;
            r_control   <= '0;
            r_countdown <= CD_RESET_VAL;
        end else if (i_step) begin
            r_divider   <= n_divider;
            r_counter   <= n_counter;
            r_reload    <= n_reload;
            r_control   <= n_control;
            r_countdown <= n_countdown;
        end
    end

    // Result reflects the state after the request
    assign o_result.divider_high    = n_divider[15:8];
    assign o_result.counter_value   = n_counter;
    assign o_result.reload_value    = n_reload;
    assign o_result.control_value   = n_control;
    assign o_result.timer_interrupt = irq;

    a_cd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_countdown != '0 && r_countdown <= CD_RESET_VAL)
        else $error("countdown out of range");

    a_enable_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.kind == KIND_WRITE && i_item.reg_select == SEL_CONTROL
        && !r_control[CTRL_EN_BIT] && i_item.write_data[CTRL_EN_BIT]
        |=> r_countdown == period_of(r_control[1:0]))
        else $error("countdown not restarted on enable");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.kind == KIND_ADVANCE && !r_control[CTRL_EN_BIT]
        |=> $stable(r_countdown) && $stable(r_counter))
        else $error("disabled timer moved");

    a_write_no_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.kind == KIND_WRITE |-> !o_result.timer_interrupt)
        else $error("interrupt on register write");

endmodule

>>> hdl/divider_and_reloading_timer.sv
// Divider and reloading timer. Each request either advances time by the
// amount in its 5-bit cycles field, clears the divider, or writes one byte
// to the counter, reload or control register; every request yields one
// response with the register values after it and an interrupt flag that is
// set when the counter overflowed and reloaded. Requests are taken one per
// clock while the response side is not stalled: a request is registered, the
// timer state is updated from it by a single pass of adders and compares, and
// the response is registered in the same step, so a stalled response only
// holds the pipeline when both registers are full.
module divider_and_reloading_timer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drt_req_if.sink   i_req,
    drt_rsp_if.source o_rsp
);
    import drt_pkg::*;

    logic  r_in_vld;
    t_req  r_in;
    logic  r_out_vld;
    t_rsp  r_out;
    logic  step;
    t_req  req_item;
    t_rsp  result;

    // Move the held request forward when the response slot is free
    assign step        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || step;

    assign req_item.kind       = i_req.kind;
    assign req_item.reg_select = i_req.reg_select;
    assign req_item.write_data = i_req.write_data;
    assign req_item.cycles     = i_req.cycles;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= req_item;
        end
    end

    drt_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.divider_high    = r_out.divider_high;
    assign o_rsp.counter_value   = r_out.counter_value;
    assign o_rsp.reload_value    = r_out.reload_value;
    assign o_rsp.control_value   = r_out.control_value;
    assign o_rsp.timer_interrupt = r_out.timer_interrupt;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !step |=> r_in_vld)
        else $error("held request dropped");

    a_irq_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.timer_interrupt
        |-> r_out.counter_value == r_out.reload_value
            || r_out.counter_value == r_out.reload_value + 8'd1)
        else $error("interrupt without reload");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("response lost");

endmodule

>>> tb/sv/drt_response_checker.sv
module drt_response_checker
    import drt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    drt_req_if   i_req,
    drt_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the timer registers
    logic [15:0]     shadow_div;
    logic [7:0]      shadow_cnt;
    logic [7:0]      shadow_rld;
    logic [2:0]      shadow_ctl;
    logic [CD_W-1:0] shadow_cd;

    // Register snapshots owed by the block, oldest first
    t_rsp owed_snapshots[$];
    int   mismatch_total = 0;
    int   owed_total = 0;

    assign o_mismatches = mismatch_total;
    assign o_awaiting   = owed_total;

    function automatic logic [CD_W-1:0] countdown_length(input logic [1:0] per);
        logic [CD_W-1:0] len;
        case (per)
            PER_16:  len = 11'd16;
            PER_64:  len = 11'd64;
            PER_256: len = 11'd256;
            default: len = 11'd1024;
        endcase
        return len;
    endfunction

    // Apply one request to the shadow registers and return the snapshot after it
    function automatic t_rsp step_shadow_timer(input t_req r);
        t_rsp       snap;
        logic       overflowed;
        logic [2:0] new_ctl;
        overflowed = 1'b0;
        if (r.kind == KIND_ADVANCE) begin
            shadow_div = shadow_div + 16'(r.cycles);
            if (shadow_ctl[CTRL_EN_BIT]) begin
                for (int c = 0; c < int'(r.cycles); c++) begin
                    shadow_cd = shadow_cd - 1'b1;
                    if (shadow_cd == '0) begin
                        if (shadow_cnt == BYTE_MAX) begin
                            shadow_cnt = shadow_rld;
                            overflowed = 1'b1;
                        end else begin
                            shadow_cnt = shadow_cnt + 8'd1;
                        end
                        shadow_cd = countdown_length(shadow_ctl[1:0]);
                    end
                end
            end
        end else begin
            case (r.reg_select)
                SEL_DIVIDER: shadow_div = '0;
                SEL_COUNTER: shadow_cnt = r.write_data;
                SEL_RELOAD:  shadow_rld = r.write_data;
                default: begin
                    new_ctl = r.write_data[2:0];
                    // Restart the countdown only on a clear-to-set enable
                    if (!shadow_ctl[CTRL_EN_BIT] && new_ctl[CTRL_EN_BIT])
                        shadow_cd = countdown_length(new_ctl[1:0]);
                    shadow_ctl = new_ctl;
                end
            endcase
        end
        snap.divider_high    = shadow_div[15:8];
        snap.counter_value   = shadow_cnt;
        snap.reload_value    = shadow_rld;
        snap.control_value   = shadow_ctl;
        snap.timer_interrupt = overflowed;
        return snap;
    endfunction

    task automatic compare_field(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    // Predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin
        t_req seen;
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            shadow_div = '0;
            shadow_cnt = '0;
            shadow_rld = '0;
            shadow_ctl = '0;
            shadow_cd  = CD_RESET_VAL;
            owed_snapshots.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                seen.kind       = i_req.kind;
                seen.reg_select = i_req.reg_select;
                seen.write_data = i_req.write_data;
                seen.cycles     = i_req.cycles;
                owed_snapshots.push_back(step_shadow_timer(seen));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.divider_high    = i_rsp.divider_high;
                got.counter_value   = i_rsp.counter_value;
                got.reload_value    = i_rsp.reload_value;
                got.control_value   = i_rsp.control_value;
                got.timer_interrupt = i_rsp.timer_interrupt;
                if (owed_snapshots.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: response with no request outstanding, expected none, actual %0h",
                             $time, got);
                end else begin
                    want = owed_snapshots.pop_front();
                    compare_field("divider_high", want.divider_high, got.divider_high);
                    compare_field("counter_value", want.counter_value, got.counter_value);
                    compare_field("reload_value", want.reload_value, got.reload_value);
                    compare_field("control_value", 8'(want.control_value),
                                  8'(got.control_value));
                    compare_field("timer_interrupt", 8'(want.timer_interrupt),
                                  8'(got.timer_interrupt));
                end
            end
        end
        owed_total = owed_snapshots.size();
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import drt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 335;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT      = 5000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    drt_req_if req_ch ();
    drt_rsp_if rsp_ch ();

    int          mismatches;
    int          awaiting;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          long_hold      = 1'b0;
    int          quiet_cycles   = 0;

    divider_and_reloading_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    drt_response_checker rsp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_awaiting   (awaiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Response side: random stalls, plus one long hold-off to back up the pipeline
    initial begin
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !held) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_req advance_req(input logic [4:0] cyc);
        t_req r;
        r.kind       = KIND_ADVANCE;
        r.reg_select = 2'($urandom_range(3));
        r.write_data = 8'($urandom);
        r.cycles     = cyc;
        return r;
    endfunction

    function automatic t_req write_req(input logic [1:0] sel, input logic [7:0] data);
        t_req r;
        r.kind       = KIND_WRITE;
        r.reg_select = sel;
        r.write_data = data;
        r.cycles     = 5'($urandom_range(31));
        return r;
    endfunction

    // Mostly advances; writes lean toward near-full counters and fast enabled periods
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        if ($urandom_range(99) < 85)
            r = advance_req(5'($urandom_range(16)));
        else
            r = advance_req(5'($urandom_range(31, 17)));
        if ($urandom_range(99) < 40) begin
            r.kind = KIND_WRITE;
            pick = $urandom_range(99);
            if (pick < 5) begin
                r.reg_select = SEL_DIVIDER;
            end else if (pick < 40) begin
                r.reg_select = SEL_COUNTER;
                if ($urandom_range(1) == 1)
                    r.write_data = 8'($urandom_range(255, 240));
            end else if (pick < 60) begin
                r.reg_select = SEL_RELOAD;
            end else begin
                r.reg_select = SEL_CONTROL;
                if ($urandom_range(99) < 70)
                    r.write_data[2:0] = {1'b1, ($urandom_range(1) == 1) ? PER_16 : PER_64};
            end
        end
        return r;
    endfunction

    // Offer one request after a random idle gap and hold it until taken
    task automatic offer_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= r.kind;
        req_ch.reg_select <= r.reg_select;
        req_ch.write_data <= r.write_data;
        req_ch.cycles     <= r.cycles;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed response has come back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned send_by_phase[4];
        int unsigned recv_by_phase[4];
        send_by_phase     = '{0, 74, 0, 16};
        recv_by_phase     = '{0, 0, 74, 16};
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_ADVANCE;
        req_ch.reg_select <= SEL_DIVIDER;
        req_ch.write_data <= '0;
        req_ch.cycles     <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes and each timer corner, no idling
        offer_request(advance_req(5'd0));
        offer_request(advance_req(5'd16));
        offer_request(advance_req(5'd31));
        offer_request(write_req(SEL_DIVIDER, 8'hFF));
        offer_request(write_req(SEL_RELOAD, 8'h00));
        offer_request(write_req(SEL_COUNTER, 8'hFF));
        offer_request(write_req(SEL_RELOAD, 8'hAB));
        offer_request(write_req(SEL_CONTROL, 8'hF8));
        // enable at period 16, then expire with overflow
        offer_request(write_req(SEL_CONTROL, 8'hFD));
        offer_request(advance_req(5'd31));
        offer_request(write_req(SEL_COUNTER, 8'hFF));
        // switch to 256 while running: the live countdown keeps going
        offer_request(write_req(SEL_CONTROL, 8'h07));
        offer_request(advance_req(5'd1));
        // disabled: counter and countdown hold
        offer_request(write_req(SEL_CONTROL, 8'h03));
        offer_request(advance_req(5'd31));
        offer_request(write_req(SEL_CONTROL, 8'h06));
        offer_request(write_req(SEL_COUNTER, 8'hFE));
        offer_request(write_req(SEL_RELOAD, 8'hFF));
        repeat (5) offer_request(advance_req(5'd31));
        // enable at period 1024 from a disabled state
        offer_request(write_req(SEL_CONTROL, 8'h00));
        offer_request(write_req(SEL_CONTROL, 8'h04));
        offer_request(advance_req(5'd31));
        drain_responses();

        // Random phases, each drained before the next
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_by_phase[phase];
            recv_stall_pct = recv_by_phase[phase];
            if (phase == 0)
                long_hold = 1'b1;
            repeat (ITEMS_PER_PHASE) offer_request(random_request());
            drain_responses();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
